### src/spae_pkg.sv
`default_nettype none

package spae_pkg;

  // Default path buffer size, terminator included
  localparam int MAX_PATH_LEN_DEF = 256;

  // Parser phase codes
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_ROUTE = 3'd2;
  localparam logic [2:0] PH_ESC   = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  // Special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // One result beat from the parser to the output register
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic [7:0] length;
  } spae_res_t;

  function automatic logic is_space_byte(input logic [7:0] b);
    is_space_byte = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_print_byte(input logic [7:0] b);
    is_print_byte = (b >= CH_SPACE) && (b <= CH_TILDE);
  endfunction

endpackage

`default_nettype wire

### src/spae_in_stage.sv
`default_nettype none

module spae_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       adv,
  output logic            s_valid,
  output logic [7:0]      s_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  // Take a new beat when empty or when the held one moves on
  assign in_ready = !valid_r || adv;
  assign s_valid  = valid_r;
  assign s_byte   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

### src/spae_parser.sv
`default_nettype none

module spae_parser
  import spae_pkg::*;
#(
  parameter int MAX_PATH_LEN = MAX_PATH_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] b,
  output spae_res_t       res
);

  localparam int         LIMIT_I = ((MAX_PATH_LEN - 1) > 255) ? 255 : (MAX_PATH_LEN - 1);
  localparam logic [7:0] LIMIT   = 8'(LIMIT_I);

  logic [2:0] phase_r, phase_nxt;
  logic       quoted_r, quoted_nxt;
  logic [7:0] count_r, count_nxt;

  always_comb begin
    logic [2:0] ph;
    logic       go;
    logic       emit;
    logic [7:0] cnt_inc;

    ph         = phase_r;
    go         = 1'b0;
    emit       = 1'b0;
    cnt_inc    = count_r + 8'd1;
    phase_nxt  = phase_r;
    quoted_nxt = quoted_r;
    count_nxt  = count_r;
    res.vld    = 1'b0;
    res.data   = b;
    res.last   = 1'b0;
    res.length = count_r;

    if (step) begin
      if (b == CH_NUL) begin
        // Terminator: report length, rearm for the next path
        res.vld    = 1'b1;
        res.data   = CH_NUL;
        res.last   = 1'b1;
        phase_nxt  = PH_LEAD;
        quoted_nxt = 1'b0;
        count_nxt  = '0;
      end else begin
        go = 1'b1;
        if (phase_r == PH_LEAD) begin
          if (is_space_byte(b)) begin
            go = 1'b0;
          end else begin
            ph = PH_BODY;
          end
        end
        if (go) begin
          phase_nxt = ph;
          unique case (ph)
            PH_BODY: begin
              if (count_r >= LIMIT) begin
                phase_nxt = PH_DONE;
              end else if (b == CH_AT) begin
                if (count_r == 8'd0) begin
                  phase_nxt = PH_ROUTE;
                end else begin
                  emit = 1'b1;
                end
              end else if (b == CH_DQUOTE) begin
                quoted_nxt = !quoted_r;
              end else if (b == CH_BSLASH) begin
                phase_nxt = PH_ESC;
              end else if (!quoted_r && (b == CH_LT)) begin
                emit = 1'b0;
              end else if (!quoted_r && (b == CH_GT)) begin
                phase_nxt = PH_DONE;
              end else begin
                emit = 1'b1;
              end
            end
            PH_ROUTE: begin
              if (b == CH_COLON) begin
                phase_nxt = PH_BODY;
              end
            end
            PH_ESC: begin
              phase_nxt = PH_BODY;
              emit      = 1'b1;
            end
            default: begin
              phase_nxt = ph;
            end
          endcase
          if (emit && is_print_byte(b)) begin
            count_nxt  = cnt_inc;
            res.vld    = 1'b1;
            res.length = cnt_inc;
            if (cnt_inc >= LIMIT) begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      quoted_r <= 1'b0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      quoted_r <= quoted_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LIMIT)
    else $error("count beyond limit");

  a_term_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.last |=> (count_r == 8'd0) && (phase_r == PH_LEAD) && !quoted_r)
    else $error("state not rearmed after terminator");

  a_data_length: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && !res.last |-> (res.length == count_r + 8'd1))
    else $error("data beat length mismatch");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_DONE) |-> (!res.vld || res.last))
    else $error("data emitted after path end");
`endif

endmodule

`default_nettype wire

### src/spae_out_stage.sv
`default_nettype none

module spae_out_stage
  import spae_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  spae_res_t       res,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [7:0]      out_length
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [7:0] length_r;

  // Room for a result when empty or the held beat is being taken
  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_length = length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.vld) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      byte_r   <= res.data;
      last_r   <= res.last;
      length_r <= res.length;
    end
  end

endmodule

`default_nettype wire

### src/smtp_path_address_extractor_core.sv
`default_nettype none

// SMTP path address extractor. Feed the bytes of one path on in_byte, closed
// by a zero byte; the cleaned address comes out one beat per kept byte, and
// the zero byte yields a final beat with out_last high, out_byte zero and
// out_length holding the byte count. Leading whitespace is skipped, a source
// route ("@host,@host:") at the start is dropped, quotes are removed,
// backslash escapes keep the next printable byte, angle brackets are
// stripped and anything after '>' is ignored. Paths longer than
// MAX_PATH_LEN-1 bytes (at most 255) are truncated silently. Throughput is
// one input beat per clock: the parser is combinational between the input
// register and the output register, so the only limit is the sink's
// out_ready. An accepted byte goes through the input register, the parser
// and output register. Bytes with no result are absorbed without a beat.
module smtp_path_address_extractor_core
  import spae_pkg::*;
#(
  parameter int MAX_PATH_LEN = MAX_PATH_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [7:0]      out_length
);

  logic       s_valid;
  logic [7:0] s_byte;
  logic       out_free;
  logic       adv;
  spae_res_t  res;

  // Advance the held byte through the parser whenever the output has room
  assign adv = s_valid && out_free;

  spae_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .adv      (adv),
    .s_valid  (s_valid),
    .s_byte   (s_byte)
  );

  spae_parser #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .b     (s_byte),
    .res   (res)
  );

  spae_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_length (out_length)
  );

endmodule

`default_nettype wire
